/* hdl/clipped_rect_alpha_fill_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the clipped rectangle fill engine
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_RECT_ALPHA_FILL_TOP_MACROS_SVH
`define CLIPPED_RECT_ALPHA_FILL_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent in this cycle implies consequent in the same cycle
`define CRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crf check failed");

// Antecedent in this cycle implies consequent in the next cycle
`define CRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crf check failed");

`else

`define CRF_ASSERT_NOW(label, ante, cons)
`define CRF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/crf_pkg.sv */
// ----------------------------------------------------------------------------
// crf_pkg
// Shared types, codes and helpers for the clipped rectangle fill pipeline.
// ----------------------------------------------------------------------------
package crf_pkg;

    // Field and bus widths
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int CH_W    = 8;
    localparam int PROD_W  = 2 * CH_W;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    // Largest value a dimension register can hold
    localparam int DIM_MAX = (2 ** DIM_W) - 1;

    // Default clip limit
    localparam int MAX_IMAGE_DIM_DEF = 4096;

    // Full-scale channel value and blend shift
    localparam logic [CH_W-1:0] ALPHA_MAX   = 8'hff;
    localparam int              BLEND_SHIFT = 8;

    // Register indexes
    localparam logic [2:0] REG_RECT_LEFT    = 3'd0;
    localparam logic [2:0] REG_RECT_TOP     = 3'd1;
    localparam logic [2:0] REG_RECT_WIDTH   = 3'd2;
    localparam logic [2:0] REG_RECT_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;
    localparam logic [2:0] REG_FILL_COLOR   = 3'd6;
    localparam logic [2:0] REG_PIXEL_FORMAT = 3'd7;

    // Pixel formats
    typedef enum logic [1:0] {
        FMT_A    = 2'd0,
        FMT_RGB  = 2'd1,
        FMT_RGBX = 2'd2,
        FMT_RGBA = 2'd3
    } fmt_t;

    // What the last stage does with the color channels
    typedef enum logic [2:0] {
        MODE_KEEP,
        MODE_ALPHA,
        MODE_OPAQUE,
        MODE_CLEAR,
        MODE_BLEND
    } mode_t;

    // Configuration register file contents
    typedef struct packed {
        logic signed [DIM_W-1:0] rect_left;
        logic signed [DIM_W-1:0] rect_top;
        logic [DIM_W-1:0]        rect_width;
        logic [DIM_W-1:0]        rect_height;
        logic [DIM_W-1:0]        image_width;
        logic [DIM_W-1:0]        image_height;
        logic [31:0]             fill_color;
        fmt_t                    pixel_format;
    } cfg_t;

    // Stage 1 result: clip decision and blend setup
    typedef struct packed {
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
        logic                   we;
        mode_t                  mode;
        logic [2:0][CH_W-1:0]   dst;
        logic [CH_W-1:0]        c3;
        logic [CH_W-1:0]        w;
    } s1_t;

    // Stage 2 result: partial products
    typedef struct packed {
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
        logic                   we;
        mode_t                  mode;
        logic [2:0][CH_W-1:0]   dst;
        logic [CH_W-1:0]        c3;
        logic [2:0][PROD_W-1:0] pd;
        logic [2:0][PROD_W-1:0] pc;
    } s2_t;

    // Final pixel result
    typedef struct packed {
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic                 we;
        logic [3:0][CH_W-1:0] ch;
    } res_t;

    // Pixel lies in [max(start,0), min(start+len, lim))
    function automatic logic in_span(
        input logic [COORD_W-1:0]     p,
        input logic signed [DIM_W-1:0] start,
        input logic [DIM_W-1:0]       len,
        input logic [DIM_W-1:0]       lim
    );
        logic signed [DIM_W+1:0] ps;
        logic signed [DIM_W+1:0] st;
        logic signed [DIM_W+1:0] hi;
        logic signed [DIM_W+1:0] lm;
        ps = signed'({{(DIM_W + 2 - COORD_W){1'b0}}, p});
        st = {{2{start[DIM_W-1]}}, start};
        hi = st + signed'({2'b00, len});
        lm = signed'({2'b00, lim});
        return (ps >= st) && (ps < hi) && (ps < lm);
    endfunction

endpackage

/* hdl/crf_clip.sv */
// ----------------------------------------------------------------------------
// crf_clip
// Stage 1: clip test against rectangle and image, blend mode and weight.
// ----------------------------------------------------------------------------
module crf_clip #(
    parameter int MAX_IMAGE_DIM = crf_pkg::MAX_IMAGE_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  crf_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [crf_pkg::COORD_W-1:0]  pixel_x,
    input  logic [crf_pkg::COORD_W-1:0]  pixel_y,
    input  logic [crf_pkg::CH_W-1:0]     dst_c0,
    input  logic [crf_pkg::CH_W-1:0]     dst_c1,
    input  logic [crf_pkg::CH_W-1:0]     dst_c2,
    input  logic [crf_pkg::CH_W-1:0]     dst_c3,
    output logic                         out_valid,
    input  logic                         out_ready,
    output crf_pkg::s1_t                 out_data
);

    // Clip limit never exceeds what a dimension register can hold
    localparam logic [crf_pkg::DIM_W-1:0] DIM_CAP =
        (MAX_IMAGE_DIM > crf_pkg::DIM_MAX) ? crf_pkg::DIM_W'(crf_pkg::DIM_MAX)
                                           : crf_pkg::DIM_W'(MAX_IMAGE_DIM);

    logic                        valid_reg;
    logic                        valid_next;
    crf_pkg::s1_t                data_reg;
    crf_pkg::s1_t                data_next;
    logic [crf_pkg::DIM_W-1:0]   lim_x;
    logic [crf_pkg::DIM_W-1:0]   lim_y;
    logic [crf_pkg::CH_W-1:0]    alpha;
    logic [crf_pkg::CH_W-1:0]    w_full;
    logic [crf_pkg::CH_W-1:0]    w_min;
    logic                        we;

    // Cap image size, test both spans
    always_comb
    begin
        lim_x  = (cfg.image_width > DIM_CAP) ? DIM_CAP : cfg.image_width;
        lim_y  = (cfg.image_height > DIM_CAP) ? DIM_CAP : cfg.image_height;
        alpha  = cfg.fill_color[crf_pkg::CH_W-1:0];
        w_full = crf_pkg::ALPHA_MAX - alpha;
        w_min  = (dst_c3 < w_full) ? dst_c3 : w_full;
        we     = (alpha != '0)
              && crf_pkg::in_span(pixel_x, cfg.rect_left, cfg.rect_width, lim_x)
              && crf_pkg::in_span(pixel_y, cfg.rect_top, cfg.rect_height, lim_y);
    end

    // Pick the channel treatment and the new alpha byte
    always_comb
    begin
        data_next.x      = pixel_x;
        data_next.y      = pixel_y;
        data_next.we     = we;
        data_next.dst[0] = dst_c0;
        data_next.dst[1] = dst_c1;
        data_next.dst[2] = dst_c2;
        data_next.mode   = crf_pkg::MODE_KEEP;
        data_next.c3     = dst_c3;
        data_next.w      = w_full;
        if (we)
        begin
            case (cfg.pixel_format)
                crf_pkg::FMT_A:
                begin
                    data_next.mode = crf_pkg::MODE_ALPHA;
                end
                default:
                begin
                    if (alpha == crf_pkg::ALPHA_MAX)
                    begin
                        data_next.mode = crf_pkg::MODE_OPAQUE;
                        if (cfg.pixel_format != crf_pkg::FMT_RGB)
                        begin
                            data_next.c3 = crf_pkg::ALPHA_MAX;
                        end
                    end
                    else if (cfg.pixel_format == crf_pkg::FMT_RGBA && dst_c3 == '0)
                    begin
                        data_next.mode = crf_pkg::MODE_CLEAR;
                        data_next.c3   = alpha;
                    end
                    else
                    begin
                        data_next.mode = crf_pkg::MODE_BLEND;
                        if (cfg.pixel_format == crf_pkg::FMT_RGBA
                            && dst_c3 != crf_pkg::ALPHA_MAX)
                        begin
                            data_next.w  = w_min;
                            data_next.c3 = w_min + alpha;
                        end
                        else if (cfg.pixel_format == crf_pkg::FMT_RGBX)
                        begin
                            data_next.c3 = crf_pkg::ALPHA_MAX;
                        end
                    end
                end
            endcase
        end
    end

    // Advance when empty or when downstream takes the current item
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hdl/crf_mul.sv */
// ----------------------------------------------------------------------------
// crf_mul
// Stage 2: destination times weight and fill color times alpha, per channel.
// ----------------------------------------------------------------------------
module crf_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  crf_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  crf_pkg::s1_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output crf_pkg::s2_t  out_data
);

    logic                            valid_reg;
    logic                            valid_next;
    crf_pkg::s2_t                    data_reg;
    crf_pkg::s2_t                    data_next;
    logic [2:0][crf_pkg::CH_W-1:0]   color;
    logic [crf_pkg::CH_W-1:0]        alpha;

    assign color[0] = cfg.fill_color[31:24];
    assign color[1] = cfg.fill_color[23:16];
    assign color[2] = cfg.fill_color[15:8];
    assign alpha    = cfg.fill_color[crf_pkg::CH_W-1:0];

    // Form the six 8x8 products
    always_comb
    begin
        data_next.x    = in_data.x;
        data_next.y    = in_data.y;
        data_next.we   = in_data.we;
        data_next.mode = in_data.mode;
        data_next.dst  = in_data.dst;
        data_next.c3   = in_data.c3;
        for (int i = 0; i < 3; i++)
        begin
            data_next.pd[i] = crf_pkg::PROD_W'(in_data.dst[i]) * crf_pkg::PROD_W'(in_data.w);
            data_next.pc[i] = crf_pkg::PROD_W'(color[i]) * crf_pkg::PROD_W'(alpha);
        end
    end

    // Advance when empty or when downstream takes the current item
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hdl/crf_mix.sv */
// ----------------------------------------------------------------------------
// crf_mix
// Stage 3: sum and shift the products, select the new bytes, output register.
// ----------------------------------------------------------------------------
module crf_mix (
    input  logic          clk,
    input  logic          rst_n,
    input  crf_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  crf_pkg::s2_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output crf_pkg::res_t out_data
);

    logic                              valid_reg;
    logic                              valid_next;
    crf_pkg::res_t                     data_reg;
    crf_pkg::res_t                     data_next;
    logic [2:0][crf_pkg::PROD_W:0]     sum;
    logic [2:0][crf_pkg::CH_W-1:0]     mixed;
    logic [2:0][crf_pkg::CH_W-1:0]     color;

    assign color[0] = cfg.fill_color[31:24];
    assign color[1] = cfg.fill_color[23:16];
    assign color[2] = cfg.fill_color[15:8];

    // Weighted sum, keep bits above the blend shift
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i]   = {1'b0, in_data.pd[i]} + {1'b0, in_data.pc[i]};
            mixed[i] = sum[i][crf_pkg::BLEND_SHIFT +: crf_pkg::CH_W];
        end
    end

    // Select the new color bytes
    always_comb
    begin
        data_next.x     = in_data.x;
        data_next.y     = in_data.y;
        data_next.we    = in_data.we;
        data_next.ch[3] = in_data.c3;
        for (int i = 0; i < 3; i++)
        begin
            data_next.ch[i] = in_data.dst[i];
        end
        case (in_data.mode)
            crf_pkg::MODE_ALPHA:
            begin
                data_next.ch[0] = cfg.fill_color[crf_pkg::CH_W-1:0];
            end
            crf_pkg::MODE_OPAQUE, crf_pkg::MODE_CLEAR:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    data_next.ch[i] = color[i];
                end
            end
            crf_pkg::MODE_BLEND:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    data_next.ch[i] = mixed[i];
                end
            end
            default:
            begin
                data_next.ch[0] = in_data.dst[0];
            end
        endcase
    end

    // Output register: hold while the consumer stalls
    assign in_ready   = !valid_reg || !out_stall;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hdl/clipped_rect_alpha_fill_top.sv */
// ----------------------------------------------------------------------------
// clipped_rect_alpha_fill_top
// Per-pixel rectangle fill with alpha blend, clipped to the image. Each
// transfer on the input channel is one destination pixel; each transfer on
// the output channel is the same pixel with its write flag and new bytes.
// The engine takes one pixel every clock while the output is not stalled and
// returns it in order through three register stages: clip compare and mode
// decode, the 8x8 channel multiplies, then the sum, shift and byte select into
// the output register. The input stall rises only when all three stages hold a
// pixel and the output is stalled. Registers sit on an APB port at byte
// addresses 4*i; write them only while no pixel is in flight.
// ----------------------------------------------------------------------------
`include "clipped_rect_alpha_fill_top_macros.svh"

module clipped_rect_alpha_fill_top #(
    parameter int MAX_IMAGE_DIM = crf_pkg::MAX_IMAGE_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [crf_pkg::APB_AW-1:0]   paddr,
    input  logic [crf_pkg::APB_DW-1:0]   pwdata,
    output logic [crf_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // pixel input
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [crf_pkg::COORD_W-1:0]  pixel_x,
    input  logic [crf_pkg::COORD_W-1:0]  pixel_y,
    input  logic [crf_pkg::CH_W-1:0]     dst_c0,
    input  logic [crf_pkg::CH_W-1:0]     dst_c1,
    input  logic [crf_pkg::CH_W-1:0]     dst_c2,
    input  logic [crf_pkg::CH_W-1:0]     dst_c3,
    // pixel result
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [crf_pkg::COORD_W-1:0]  out_x,
    output logic [crf_pkg::COORD_W-1:0]  out_y,
    output logic                         write_enable,
    output logic [crf_pkg::CH_W-1:0]     new_c0,
    output logic [crf_pkg::CH_W-1:0]     new_c1,
    output logic [crf_pkg::CH_W-1:0]     new_c2,
    output logic [crf_pkg::CH_W-1:0]     new_c3
);

    crf_pkg::cfg_t  cfg_reg;
    crf_pkg::cfg_t  cfg_next;
    logic           cfg_write;
    logic [2:0]     reg_index;

    logic           s1_ready;
    logic           s1_valid;
    crf_pkg::s1_t   s1_data;
    logic           s2_ready;
    logic           s2_valid;
    crf_pkg::s2_t   s2_data;
    logic           s3_ready;
    crf_pkg::res_t  res;

    // Register write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[crf_pkg::APB_AW-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        case (reg_index)
            crf_pkg::REG_RECT_LEFT:    cfg_next.rect_left    = signed'(pwdata[crf_pkg::DIM_W-1:0]);
            crf_pkg::REG_RECT_TOP:     cfg_next.rect_top     = signed'(pwdata[crf_pkg::DIM_W-1:0]);
            crf_pkg::REG_RECT_WIDTH:   cfg_next.rect_width   = pwdata[crf_pkg::DIM_W-1:0];
            crf_pkg::REG_RECT_HEIGHT:  cfg_next.rect_height  = pwdata[crf_pkg::DIM_W-1:0];
            crf_pkg::REG_IMAGE_WIDTH:  cfg_next.image_width  = pwdata[crf_pkg::DIM_W-1:0];
            crf_pkg::REG_IMAGE_HEIGHT: cfg_next.image_height = pwdata[crf_pkg::DIM_W-1:0];
            crf_pkg::REG_FILL_COLOR:   cfg_next.fill_color   = pwdata;
            crf_pkg::REG_PIXEL_FORMAT: cfg_next.pixel_format = crf_pkg::fmt_t'(pwdata[1:0]);
            default:                   cfg_next = cfg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rect_left    <= '0;
            cfg_reg.rect_top     <= '0;
            cfg_reg.rect_width   <= '0;
            cfg_reg.rect_height  <= '0;
            cfg_reg.image_width  <= crf_pkg::DIM_W'(4096);
            cfg_reg.image_height <= crf_pkg::DIM_W'(4096);
            cfg_reg.fill_color   <= '0;
            cfg_reg.pixel_format <= crf_pkg::FMT_RGBA;
        end
        else if (cfg_write)
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read-back
    always_comb
    begin
        case (reg_index)
            crf_pkg::REG_RECT_LEFT:    prdata = 32'(unsigned'(cfg_reg.rect_left));
            crf_pkg::REG_RECT_TOP:     prdata = 32'(unsigned'(cfg_reg.rect_top));
            crf_pkg::REG_RECT_WIDTH:   prdata = 32'(cfg_reg.rect_width);
            crf_pkg::REG_RECT_HEIGHT:  prdata = 32'(cfg_reg.rect_height);
            crf_pkg::REG_IMAGE_WIDTH:  prdata = 32'(cfg_reg.image_width);
            crf_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_reg.image_height);
            crf_pkg::REG_FILL_COLOR:   prdata = cfg_reg.fill_color;
            crf_pkg::REG_PIXEL_FORMAT: prdata = 32'(cfg_reg.pixel_format);
            default:                   prdata = '0;
        endcase
    end

    // Stage 1: clip and decode
    crf_clip #(
        .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
    ) u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (s1_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .dst_c0    (dst_c0),
        .dst_c1    (dst_c1),
        .dst_c2    (dst_c2),
        .dst_c3    (dst_c3),
        .out_valid (s1_valid),
        .out_ready (s2_ready),
        .out_data  (s1_data)
    );

    // Stage 2: multiplies
    crf_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s1_valid),
        .in_ready  (s2_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s3_ready),
        .out_data  (s2_data)
    );

    // Stage 3: sum, select, output register
    crf_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s2_valid),
        .in_ready  (s3_ready),
        .in_data   (s2_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (res)
    );

    assign in_stall     = !s1_ready;
    assign out_x        = res.x;
    assign out_y        = res.y;
    assign write_enable = res.we;
    assign new_c0       = res.ch[0];
    assign new_c1       = res.ch[1];
    assign new_c2       = res.ch[2];
    assign new_c3       = res.ch[3];

    // Push back only when every stage is occupied
    `CRF_ASSERT_NOW(a_stall_full, in_stall, s1_valid && s2_valid && out_valid && out_stall)
    // A stage-1 pixel taken by stage 2 shows up there next cycle
    `CRF_ASSERT_NEXT(a_s2_fill, s1_valid && s2_ready, s2_valid)
    // No pixel appears in stage 1 without an input transfer
    `CRF_ASSERT_NEXT(a_s1_no_ghost, !in_valid && s1_ready, !s1_valid)

endmodule
